@@ hdl/substring_search_top_defines.svh @@
// Assertion macros shared by the substring search block.
`ifndef SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define SUBSTRING_SEARCH_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define SS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define SS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ss_pkg.sv @@
`timescale 1ns / 1ps

package ss_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int POSITION_BITS = 16;

  localparam int PAT_BYTES = 16;
  localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int OUT_W     = 16;
  localparam int OUT_MAX   = 65535;
  localparam int CMP_W     = (POSITION_BITS > OUT_W) ? POSITION_BITS : OUT_W;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;
  localparam int CFG_LEN_W = 5;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [63:0]          pattern_low;
    logic [63:0]          pattern_high;
    logic [CFG_LEN_W-1:0] pattern_length;
  } cfg_t;

  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] pos;
  } match_t;

endpackage

@@ hdl/ss_cfg.sv @@
`timescale 1ns / 1ps

module ss_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ss_pkg::ADDR_W-1:0]   paddr,
  input  logic [ss_pkg::DATA_W-1:0]   pwdata,
  output logic [ss_pkg::DATA_W-1:0]   prdata,
  output logic                        pready,
  output ss_pkg::cfg_t                cfg
);

  ss_pkg::cfg_t        cfg_q;
  ss_pkg::reg_index_t  reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_sel = ss_pkg::reg_index_t'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        ss_pkg::REG_PATTERN_LOW:    cfg_q.pattern_low    <= pwdata;
        ss_pkg::REG_PATTERN_HIGH:   cfg_q.pattern_high   <= pwdata;
        ss_pkg::REG_PATTERN_LENGTH: cfg_q.pattern_length <= pwdata[ss_pkg::CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ss_pkg::REG_PATTERN_LOW:    prdata = cfg_q.pattern_low;
      ss_pkg::REG_PATTERN_HIGH:   prdata = cfg_q.pattern_high;
      ss_pkg::REG_PATTERN_LENGTH: prdata = ss_pkg::DATA_W'(cfg_q.pattern_length);
      default:                    prdata = '0;
    endcase
  end

endmodule

@@ hdl/ss_compare.sv @@
`timescale 1ns / 1ps

module ss_compare (
  input  logic [7:0]                       window_next [ss_pkg::PATTERN_MAX],
  input  logic [ss_pkg::POSITION_BITS-1:0] count_next,
  input  logic                             reported,
  input  ss_pkg::cfg_t                     cfg,
  output ss_pkg::match_t                   match
);

  localparam logic [ss_pkg::POSITION_BITS-1:0] COUNT_MAX = '1;

  logic [7:0]                       pat [ss_pkg::PAT_BYTES];
  logic [ss_pkg::LEN_W-1:0]         len;
  logic [ss_pkg::LEN_W-1:0]         tap [ss_pkg::PATTERN_MAX];
  logic                             eq;
  logic [ss_pkg::POSITION_BITS-1:0] pos_full;
  logic [ss_pkg::CMP_W-1:0]         pos_ext;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pat[i]     = cfg.pattern_low[8*i +: 8];
      pat[i + 8] = cfg.pattern_high[8*i +: 8];
    end
  end

  // Clamp the length to the window depth
  assign len = (cfg.pattern_length > ss_pkg::CFG_LEN_W'(ss_pkg::PATTERN_MAX))
             ? ss_pkg::LEN_W'(ss_pkg::PATTERN_MAX)
             : ss_pkg::LEN_W'(cfg.pattern_length);

  // Pattern byte k lines up with window entry len-1-k
  always_comb begin
    eq = 1'b1;
    for (int k = 0; k < ss_pkg::PATTERN_MAX; k++) begin
      tap[k] = len - ss_pkg::LEN_W'(k) - ss_pkg::LEN_W'(1);
      if (ss_pkg::LEN_W'(k) < len) begin
        if (pat[k] != window_next[tap[k][ss_pkg::IDX_W-1:0]]) begin
          eq = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (len == '0) begin
      pos_full = '0;
    end else if (count_next == COUNT_MAX) begin
      pos_full = COUNT_MAX;
    end else begin
      pos_full = count_next - ss_pkg::POSITION_BITS'(len);
    end
  end

  assign pos_ext = ss_pkg::CMP_W'(pos_full);

  assign match.hit = !reported && eq
                   && (count_next >= ss_pkg::POSITION_BITS'(len));
  assign match.pos = (pos_ext > ss_pkg::CMP_W'(ss_pkg::OUT_MAX))
                   ? ss_pkg::OUT_W'(ss_pkg::OUT_MAX)
                   : ss_pkg::OUT_W'(pos_ext);

endmodule

@@ hdl/substring_search_top.sv @@
`timescale 1ns / 1ps
// A result is registered when the request carrying its byte leaves the input register.
// Throughput: one byte per cycle unless out_stall holds a result, set by the combinational
//   window compare between the input and result registers; at most one result per text.
// Reset (rst, synchronous): clears the pattern registers, the byte window, the count,
//   the reported flag and both pipeline valids.
`include "substring_search_top_defines.svh"

module substring_search_top (
  input  logic                      clk,
  input  logic                      rst,
  // Text byte requests
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                text_byte,
  input  logic                      last_byte,
  // Search results
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      found,
  output logic [ss_pkg::OUT_W-1:0]  match_position,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ss_pkg::ADDR_W-1:0] paddr,
  input  logic [ss_pkg::DATA_W-1:0] pwdata,
  output logic [ss_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);

  localparam logic [ss_pkg::POSITION_BITS-1:0] COUNT_MAX = '1;

  ss_pkg::cfg_t   cfg;
  ss_pkg::match_t match;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Per-text search state
  logic [7:0]                       window      [ss_pkg::PATTERN_MAX];
  logic [7:0]                       window_next [ss_pkg::PATTERN_MAX];
  logic [ss_pkg::POSITION_BITS-1:0] count;
  logic [ss_pkg::POSITION_BITS-1:0] count_next;
  logic                             reported;

  logic move;
  logic process;
  logic emit;

  ss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The result register can take a new value when empty or being drained this cycle
  assign move     = !out_valid || !out_stall;
  assign process  = s1_valid && move;
  // Hold the request only when the input register is full and cannot advance
  assign in_stall = s1_valid && !move;

  // Shift the new byte into the newest slot of the window
  always_comb begin
    window_next[0] = s1_byte;
    for (int i = 1; i < ss_pkg::PATTERN_MAX; i++) begin
      window_next[i] = window[i-1];
    end
  end

  // Saturate the byte count at its maximum
  assign count_next = (count == COUNT_MAX) ? count : count + 1'b1;

  ss_compare u_compare (
    .window_next (window_next),
    .count_next  (count_next),
    .reported    (reported),
    .cfg         (cfg),
    .match       (match)
  );

  // A match reports itself; the final byte reports "not found" if nothing was reported
  assign emit = match.hit || (s1_last && !reported);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= text_byte;
      s1_last <= last_byte;
    end
  end

  // Advance the search state; the final byte clears it for the next text
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ss_pkg::PATTERN_MAX; i++) begin
        window[i] <= '0;
      end
      count    <= '0;
      reported <= 1'b0;
    end else if (process) begin
      if (s1_last) begin
        for (int i = 0; i < ss_pkg::PATTERN_MAX; i++) begin
          window[i] <= '0;
        end
        count    <= '0;
        reported <= 1'b0;
      end else begin
        window   <= window_next;
        count    <= count_next;
        reported <= reported || match.hit;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= emit;
    end else if (move) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      found          <= match.hit;
      match_position <= match.hit ? match.pos : '0;
    end
  end

  `SS_ASSERT_SAME(a_not_found_zero_pos, out_valid && !found, match_position == '0, "not-found result carries a nonzero position")
  `SS_ASSERT_SAME(a_stall_cause, in_stall, s1_valid && out_valid && out_stall, "input stalled without a blocked result")
  `SS_ASSERT_NEXT(a_last_clears, process && s1_last, count == '0 && !reported, "state not cleared after final byte")
  `SS_ASSERT_NEXT(a_hit_marks, process && match.hit && !s1_last, reported && out_valid && found, "match not recorded")

endmodule

@@ bench/tb_substring_search_top.sv @@
`timescale 1ns / 1ps

module tb_substring_search_top;

  // Hard stop well beyond the slowest legal run.
  localparam int unsigned RUN_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_REQUESTS = 1600;

  // How an accepted request is turned into an expectation.
  typedef enum logic [1:0] {
    CHECK_MODEL,  // take whatever the predictor works out
    CHECK_GIVEN,  // result typed into the directed list
    CHECK_NONE    // typed: this request gives no result
  } check_kind_t;

  // One line of the directed list: either a register write or a text byte.
  typedef struct {
    bit                 is_write;
    ss_pkg::reg_index_t idx;
    logic [63:0]        value;
    logic [7:0]         text;
    logic               last;
    check_kind_t        chk;
    logic               hit;
    logic [15:0]        pos;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [7:0]                text_byte = '0;
  logic                      last_byte = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      found;
  logic [ss_pkg::OUT_W-1:0]  match_position;
  logic                      psel      = 1'b0;
  logic                      penable   = 1'b0;
  logic                      pwrite    = 1'b0;
  logic [ss_pkg::ADDR_W-1:0] paddr     = '0;
  logic [ss_pkg::DATA_W-1:0] pwdata    = '0;
  logic [ss_pkg::DATA_W-1:0] prdata;
  logic                      pready;

  // Expectation tag travelling alongside the request payload.
  check_kind_t       req_chk   = CHECK_MODEL;
  logic              req_hit   = 1'b0;
  logic [15:0]       req_pos   = '0;

  // Shadow of the configuration registers.
  logic [63:0]                  shadow_low  = '0;
  logic [63:0]                  shadow_high = '0;
  logic [ss_pkg::CFG_LEN_W-1:0] shadow_len  = '0;

  // Predictor state for the text in progress.
  logic [7:0]                       recent_bytes [ss_pkg::PATTERN_MAX];
  logic [ss_pkg::POSITION_BITS-1:0] text_count = '0;
  bit                               reported   = 1'b0;

  ss_pkg::match_t expected_matches [$];
  step_t          directed_steps [$];
  int unsigned    fail_count   = 0;
  int unsigned    cycle_count  = 0;
  int unsigned    requests_out = 0;
  bit             no_gaps      = 1'b0;

  substring_search_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .text_byte      (text_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found          (found),
    .match_position (match_position),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    foreach (recent_bytes[i]) recent_bytes[i] = '0;
  end

  // Append one expected result to the tail of the queue.
  function automatic void queue_expected(input ss_pkg::match_t m);
    expected_matches.insert(expected_matches.size(), m);
  endfunction

  // Append one line to the directed list.
  function automatic void queue_step(input step_t s);
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  // Advance the search by one text byte: shift the window, bump the saturating
  // count, compare the newest bytes against the pattern and close the text on
  // its last byte.
  function automatic void advance_search(input logic [7:0] b, input logic last,
                                         output bit produced, output ss_pkg::match_t res);
    int unsigned len;
    bit          same;
    logic [7:0]  pk;
    produced = 1'b0;
    res      = '0;
    len = (shadow_len > ss_pkg::PATTERN_MAX) ? ss_pkg::PATTERN_MAX : shadow_len;
    for (int i = ss_pkg::PATTERN_MAX - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = b;
    if (text_count != '1) text_count = text_count + 1'b1;
    if (!reported && text_count >= len) begin
      same = 1'b1;
      for (int unsigned k = 0; k < len; k++) begin
        pk = (k < 8) ? shadow_low[8*k +: 8] : shadow_high[8*(k-8) +: 8];
        if (pk != recent_bytes[len-1-k]) same = 1'b0;
      end
      if (same) begin
        res.hit = 1'b1;
        // Once the count has saturated, the saturated count is the position.
        if (len == 0) res.pos = '0;
        else if (text_count == '1) res.pos = '1;
        else res.pos = ss_pkg::OUT_W'(text_count - len);
        produced = 1'b1;
        reported = 1'b1;
      end
    end
    if (last) begin
      if (!reported) begin
        res      = '0;
        produced = 1'b1;
      end
      foreach (recent_bytes[i]) recent_bytes[i] = '0;
      text_count = '0;
      reported   = 1'b0;
    end
  endfunction

  // Watch both channels at every edge: retire results first, then queue the
  // expectation for a request taken at the same edge.
  always @(posedge clk) begin : watch_channels
    bit             produced;
    ss_pkg::match_t predicted;
    ss_pkg::match_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_matches.size() == 0) begin
          $error("result with none expected: found=%0d match_position=%0d",
                 found, match_position);
          fail_count++;
        end else begin
          want = expected_matches.pop_front();
          if (found !== want.hit) begin
            $error("found: expected %0d, got %0d", want.hit, found);
            fail_count++;
          end
          if (match_position !== want.pos) begin
            $error("match_position: expected %0d, got %0d", want.pos, match_position);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_search(text_byte, last_byte, produced, predicted);
        case (req_chk)
          CHECK_MODEL: begin
            if (produced) queue_expected(predicted);
          end
          CHECK_GIVEN: begin
            want.hit = req_hit;
            want.pos = req_pos;
            queue_expected(want);
          end
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver side: mostly brief stalls, a few long ones, now and then a long
  // stretch with no stall at all.
  initial begin : receiver_stall
    int unsigned r;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      out_stall <= 1'b0;
      if (r < 8) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      out_stall <= 1'b1;
      if (r > 85) repeat ($urandom_range(5, 25)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Offer one request and hold it until taken; then idle for a random gap.
  task automatic send_request(input logic [7:0] b, input logic last, input check_kind_t chk,
                              input logic hit = 1'b0, input logic [15:0] pos = 16'h0);
    int unsigned gap;
    text_byte <= b;
    last_byte <= last;
    req_chk   <= chk;
    req_hit   <= hit;
    req_pos   <= pos;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    requests_out++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result, then idle long enough for a
  // byte that gives no result to clear the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input ss_pkg::reg_index_t idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ss_pkg::ADDR_W'(idx) << 3;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ss_pkg::REG_PATTERN_LOW:    shadow_low  = value;
      ss_pkg::REG_PATTERN_HIGH:   shadow_high = value;
      ss_pkg::REG_PATTERN_LENGTH: shadow_len  = value[ss_pkg::CFG_LEN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic void add_write(input ss_pkg::reg_index_t idx, input logic [63:0] value);
    step_t s;
    s = '{1'b1, idx, value, 8'h00, 1'b0, CHECK_NONE, 1'b0, 16'h0};
    queue_step(s);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic last,
                                   input check_kind_t chk, input logic hit = 1'b0,
                                   input logic [15:0] pos = 16'h0);
    step_t s;
    s = '{1'b0, ss_pkg::REG_UNUSED, 64'h0, b, last, chk, hit, pos};
    queue_step(s);
  endfunction

  // One random setting of the pattern, followed by a handful of texts. Most
  // bytes come from a small per-phase alphabet so that matches are common;
  // about half the texts carry a planted copy of the pattern.
  task automatic random_phase();
    logic [7:0]  letters [4];
    logic [7:0]  pat [ss_pkg::PATTERN_MAX];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  b;
    int unsigned len;
    int unsigned eff;
    int unsigned tlen;
    int unsigned plant_at;
    int unsigned pick;
    bit          plant;
    drain();
    if ($urandom_range(0, 4) == 0) letters = '{8'h00, 8'hFF, 8'h00, 8'hFF};
    else foreach (letters[i]) letters[i] = 8'($urandom);
    foreach (pat[i]) pat[i] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                          : letters[$urandom_range(0, 3)];
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pat[i];
      hi[8*i +: 8] = pat[i+8];
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) len = 0;
    else if (pick == 1) len = ss_pkg::PATTERN_MAX;
    else if (pick == 2) len = $urandom_range(ss_pkg::PATTERN_MAX + 1, 31);
    else len = $urandom_range(1, 6);
    eff = (len > ss_pkg::PATTERN_MAX) ? ss_pkg::PATTERN_MAX : len;
    write_reg(ss_pkg::REG_PATTERN_LOW, lo);
    write_reg(ss_pkg::REG_PATTERN_HIGH, hi);
    write_reg(ss_pkg::REG_PATTERN_LENGTH, 64'(len));
    no_gaps = ($urandom_range(0, 5) == 0);
    repeat ($urandom_range(3, 10)) begin
      tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 20);
      plant = ($urandom_range(0, 1) == 1) && (tlen >= eff);
      plant_at = plant ? $urandom_range(0, tlen - eff) : 0;
      for (int unsigned i = 0; i < tlen; i++) begin
        if (plant && i >= plant_at && i < plant_at + eff) b = pat[i-plant_at];
        else if ($urandom_range(0, 3) == 0) b = 8'($urandom);
        else b = letters[$urandom_range(0, 3)];
        send_request(b, i == tlen - 1, CHECK_MODEL);
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty pattern straight after reset: the first byte of each text hits at
    // position 0, also when that byte closes the text.
    add_byte(8'h00, 1'b0, CHECK_GIVEN, 1'b1, 16'd0);
    add_byte(8'hFF, 1'b1, CHECK_NONE);
    add_byte(8'hA5, 1'b1, CHECK_GIVEN, 1'b1, 16'd0);
    // Pattern "abc": hit mid-text, then quiet until the text closes.
    add_write(ss_pkg::REG_PATTERN_LOW, 64'h0000_0000_0063_6261);
    add_write(ss_pkg::REG_PATTERN_LENGTH, 64'd3);
    add_byte(8'h78, 1'b0, CHECK_MODEL);
    add_byte(8'h61, 1'b0, CHECK_MODEL);
    add_byte(8'h62, 1'b0, CHECK_MODEL);
    add_byte(8'h63, 1'b0, CHECK_GIVEN, 1'b1, 16'd1);
    add_byte(8'h64, 1'b1, CHECK_NONE);
    // Hit on the closing byte.
    add_byte(8'h61, 1'b0, CHECK_MODEL);
    add_byte(8'h62, 1'b0, CHECK_MODEL);
    add_byte(8'h63, 1'b1, CHECK_GIVEN, 1'b1, 16'd0);
    // Text ends without a hit.
    add_byte(8'h7A, 1'b1, CHECK_GIVEN, 1'b0, 16'd0);
    // Shorten the pattern mid-text: the next comparison uses the new length.
    add_byte(8'h61, 1'b0, CHECK_MODEL);
    add_write(ss_pkg::REG_PATTERN_LENGTH, 64'd1);
    add_byte(8'h61, 1'b0, CHECK_GIVEN, 1'b1, 16'd1);
    add_byte(8'h71, 1'b1, CHECK_NONE);
    // Length above the maximum acts as the full sixteen bytes.
    add_write(ss_pkg::REG_PATTERN_LOW, 64'h0);
    add_write(ss_pkg::REG_PATTERN_HIGH, '1);
    add_write(ss_pkg::REG_PATTERN_LENGTH, 64'd31);
    for (int i = 0; i < 8; i++) add_byte(8'h00, 1'b0, CHECK_MODEL);
    for (int i = 0; i < 7; i++) add_byte(8'hFF, 1'b0, CHECK_MODEL);
    add_byte(8'hFF, 1'b1, CHECK_GIVEN, 1'b1, 16'd0);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_write) begin
        drain();
        write_reg(directed_steps[i].idx, directed_steps[i].value);
      end else begin
        send_request(directed_steps[i].text, directed_steps[i].last, directed_steps[i].chk,
                     directed_steps[i].hit, directed_steps[i].pos);
      end
    end

    requests_out = 0;
    while (requests_out < RANDOM_REQUESTS) random_phase();

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_matches.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/ss_pkg.sv
hdl/ss_cfg.sv
hdl/ss_compare.sv
hdl/substring_search_top.sv
bench/tb_substring_search_top.sv
